// ----- rtl/core/process_record_sorter_defines.svh -----
// Assertion macros for the process record sorter.
// Included by the top level; expects aclk and aresetn in scope.
`ifndef PROCESS_RECORD_SORTER_DEFINES_SVH
`define PROCESS_RECORD_SORTER_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define PRS_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("process_record_sorter: same-cycle check failed");

// The consequent must hold in the cycle after the antecedent.
`define PRS_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("process_record_sorter: next-cycle check failed");

`endif

// ----- rtl/core/prs_pkg.sv -----
// Shared types and constants for the process record sorter.
// No dependencies; used by every module of the block.
package prs_pkg;

    localparam int PID_W       = 22;
    localparam int OWNER_W     = 32;
    localparam int LOAD_W      = 7;
    localparam int PAGES_W     = 32;
    localparam int THREADS_W   = 16;
    localparam int KEY_W       = 32;
    localparam int CFG_INDEX_W = 4;
    localparam int CFG_DATA_W  = 8;

    // Configuration register indexes.
    localparam logic [CFG_INDEX_W-1:0] REG_SORT_KEY   = 4'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_SORT_ORDER = 4'd1;

    // Sort key selection codes.
    localparam logic [1:0] KEY_PID     = 2'd0;
    localparam logic [1:0] KEY_LOAD    = 2'd1;
    localparam logic [1:0] KEY_PAGES   = 2'd2;
    localparam logic [1:0] KEY_THREADS = 2'd3;

    // Sort direction codes.
    localparam logic ORDER_DESC = 1'b0;
    localparam logic ORDER_ASC  = 1'b1;

    typedef struct packed {
        logic [1:0] key;
        logic       order;
    } sort_cfg_t;

    typedef struct packed {
        logic [PID_W-1:0]     proc_id;
        logic [OWNER_W-1:0]   owner_id;
        logic [LOAD_W-1:0]    load_pct;
        logic [PAGES_W-1:0]   resident_pages;
        logic [THREADS_W-1:0] thread_count;
    } rec_t;

    typedef struct packed {
        logic [PID_W-1:0]     proc_id;
        logic [OWNER_W-1:0]   owner_id;
        logic [LOAD_W-1:0]    load_pct;
        logic [PAGES_W-1:0]   resident_pages;
        logic [THREADS_W-1:0] thread_count;
        logic                 final_record;
    } in_rec_t;

    typedef struct packed {
        logic [PID_W-1:0]     out_proc_id;
        logic [OWNER_W-1:0]   out_owner_id;
        logic [LOAD_W-1:0]    out_load_pct;
        logic [PAGES_W-1:0]   out_resident_pages;
        logic [THREADS_W-1:0] out_thread_count;
        logic                 out_final;
        logic                 records_dropped;
    } out_rec_t;

endpackage

// ----- rtl/core/prs_store.sv -----
// Record store: one write port and one registered read port.
// Depends on prs_pkg for the record type.
module prs_store #(
    parameter int DEPTH = 64
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  prs_pkg::rec_t            wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output prs_pkg::rec_t            rd_data
);

    prs_pkg::rec_t mem [DEPTH];
    prs_pkg::rec_t rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ----- rtl/core/prs_key_cmp.sv -----
// Shared compare unit: decides whether two neighbouring records exchange places.
// Depends on prs_pkg for the record and configuration types.
module prs_key_cmp (
    input  prs_pkg::sort_cfg_t cfg,
    input  prs_pkg::rec_t      cur,
    input  prs_pkg::rec_t      nxt,
    output logic               swap
);

    function automatic logic [prs_pkg::KEY_W-1:0] key_of(input prs_pkg::rec_t r,
                                                         input logic [1:0] sel);
        logic [prs_pkg::KEY_W-1:0] k;
        unique case (sel)
            prs_pkg::KEY_PID:     k = prs_pkg::KEY_W'(r.proc_id);
            prs_pkg::KEY_LOAD:    k = prs_pkg::KEY_W'(r.load_pct);
            prs_pkg::KEY_PAGES:   k = prs_pkg::KEY_W'(r.resident_pages);
            prs_pkg::KEY_THREADS: k = prs_pkg::KEY_W'(r.thread_count);
            default:              k = prs_pkg::KEY_W'(r.proc_id);
        endcase
        return k;
    endfunction

    logic [prs_pkg::KEY_W-1:0] cur_key;
    logic [prs_pkg::KEY_W-1:0] nxt_key;

    assign cur_key = key_of(cur, cfg.key);
    assign nxt_key = key_of(nxt, cfg.key);

    // Strict compares only, so equal keys never move and the sort stays stable.
    assign swap = (cfg.order == prs_pkg::ORDER_ASC) ? (nxt_key < cur_key)
                                                    : (nxt_key > cur_key);

endmodule

// ----- rtl/core/process_record_sorter.sv -----
// Process record sorter top level: sequencer, configuration and output register.
// Depends on prs_pkg, prs_store, prs_key_cmp and process_record_sorter_defines.svh.
//
// Usage. Records arrive on the s_ channel, one per transaction, and are written
// to the record store at one per cycle while s_ready is high. A record with
// final_record set closes the set. Records beyond MAX_RECORDS are discarded and
// every result of that set then carries records_dropped.
// After the final record the block drops s_ready and runs a stable bubble sort
// on the key chosen by the configuration registers, using one compare unit and
// the single read and write port of the store. Passes stop after one that
// moves nothing; a set of one record is not sorted at all. The sorted records
// then leave on the m_ channel, the first after a store read in S_OUT_RD and
// the load of the output register in S_OUT, then one per cycle while m_ready
// stays high. The last one carries out_final. A stalled receiver simply holds
// the output register; the store read pointer waits with it.
// s_ready returns as soon as the last result has entered the output register,
// so the next set may load while that result is still waiting to be taken.
// Configuration is written on the cfg_ channel, which is always ready; index 0
// is sort_key and index 1 is sort_order. Reset empties the store (by clearing
// the record count), clears both registers and leaves no result pending.
`include "process_record_sorter_defines.svh"

module process_record_sorter #(
    parameter int MAX_RECORDS = 64
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  prs_pkg::in_rec_t                    s_data,
    output logic                                m_valid,
    input  logic                                m_ready,
    output prs_pkg::out_rec_t                   m_data,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [prs_pkg::CFG_INDEX_W-1:0]     cfg_index,
    input  logic [prs_pkg::CFG_DATA_W-1:0]      cfg_data
);

    localparam int IDX_W = $clog2(MAX_RECORDS);
    localparam int CNT_W = $clog2(MAX_RECORDS + 1);

    typedef enum logic [2:0] {
        S_LOAD,
        S_PASS_RD,
        S_PASS_LD,
        S_STEP,
        S_PASS_END,
        S_OUT_RD,
        S_OUT
    } state_t;

    state_t             state_reg, state_next;
    logic [CNT_W-1:0]   count_reg, count_next;
    logic               overflow_reg, overflow_next;
    logic [CNT_W-1:0]   pass_reg, pass_next;
    logic [IDX_W-1:0]   idx_reg, idx_next;
    logic               moved_reg, moved_next;
    prs_pkg::rec_t      carry_reg, carry_next;
    logic               m_valid_reg, m_valid_next;
    prs_pkg::out_rec_t  m_data_reg, m_data_next;
    prs_pkg::sort_cfg_t cfg_reg, cfg_next;

    logic               wr_en;
    logic [IDX_W-1:0]   wr_addr;
    prs_pkg::rec_t      wr_data;
    logic               rd_en;
    logic [IDX_W-1:0]   rd_addr;
    prs_pkg::rec_t      rd_data;
    logic               swap;
    logic               out_load;
    logic               out_last;

    prs_store #(
        .DEPTH (MAX_RECORDS)
    ) u_store (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    // The carried record is the one bubbling along the pass; the store read
    // data is its right-hand neighbour.
    prs_key_cmp u_cmp (
        .cfg  (cfg_reg),
        .cur  (carry_reg),
        .nxt  (rd_data),
        .swap (swap)
    );

    assign s_ready   = (state_reg == S_LOAD);
    assign cfg_ready = 1'b1;
    assign m_valid   = m_valid_reg;
    assign m_data    = m_data_reg;
    assign out_last  = ((CNT_W'(idx_reg) + CNT_W'(1)) == count_reg);

    // Register writes keep only the bits each register holds.
    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_valid) begin
            case (cfg_index)
                prs_pkg::REG_SORT_KEY:   cfg_next.key   = cfg_data[1:0];
                prs_pkg::REG_SORT_ORDER: cfg_next.order = cfg_data[0];
                default:                 cfg_next       = cfg_reg;
            endcase
        end
    end

    always_comb begin
        state_next    = state_reg;
        count_next    = count_reg;
        overflow_next = overflow_reg;
        pass_next     = pass_reg;
        idx_next      = idx_reg;
        moved_next    = moved_reg;
        carry_next    = carry_reg;
        m_valid_next  = m_valid_reg && !m_ready;
        m_data_next   = m_data_reg;
        wr_en         = 1'b0;
        wr_addr       = idx_reg;
        wr_data       = carry_reg;
        rd_en         = 1'b0;
        rd_addr       = '0;
        out_load      = 1'b0;

        unique case (state_reg)
            S_LOAD: begin
                if (s_valid) begin
                    if (count_reg < CNT_W'(MAX_RECORDS)) begin
                        wr_en                  = 1'b1;
                        wr_addr                = IDX_W'(count_reg);
                        wr_data.proc_id        = s_data.proc_id;
                        wr_data.owner_id       = s_data.owner_id;
                        wr_data.load_pct       = s_data.load_pct;
                        wr_data.resident_pages = s_data.resident_pages;
                        wr_data.thread_count   = s_data.thread_count;
                        count_next             = count_reg + CNT_W'(1);
                    end else begin
                        overflow_next = 1'b1;
                    end
                    if (s_data.final_record) begin
                        idx_next  = '0;
                        pass_next = CNT_W'(1);
                        if (count_next == CNT_W'(1)) begin
                            state_next = S_OUT_RD;
                        end else begin
                            state_next = S_PASS_RD;
                        end
                    end
                end
            end
            S_PASS_RD: begin
                rd_en      = 1'b1;
                rd_addr    = '0;
                state_next = S_PASS_LD;
            end
            S_PASS_LD: begin
                carry_next = rd_data;
                rd_en      = 1'b1;
                rd_addr    = IDX_W'(1);
                idx_next   = '0;
                moved_next = 1'b0;
                state_next = S_STEP;
            end
            S_STEP: begin
                // The record that stays behind is written back; the other one
                // travels on in the carry register.
                wr_en   = 1'b1;
                wr_addr = idx_reg;
                if (swap) begin
                    wr_data    = rd_data;
                    moved_next = 1'b1;
                end else begin
                    wr_data    = carry_reg;
                    carry_next = rd_data;
                end
                if ((CNT_W'(idx_reg) + CNT_W'(2)) == count_reg) begin
                    state_next = S_PASS_END;
                end else begin
                    rd_en    = 1'b1;
                    rd_addr  = idx_reg + IDX_W'(2);
                    idx_next = idx_reg + IDX_W'(1);
                end
            end
            S_PASS_END: begin
                wr_en   = 1'b1;
                wr_addr = IDX_W'(count_reg - CNT_W'(1));
                wr_data = carry_reg;
                if (moved_reg && ((pass_reg + CNT_W'(1)) < count_reg)) begin
                    pass_next  = pass_reg + CNT_W'(1);
                    rd_en      = 1'b1;
                    rd_addr    = '0;
                    state_next = S_PASS_LD;
                end else begin
                    idx_next   = '0;
                    state_next = S_OUT_RD;
                end
            end
            S_OUT_RD: begin
                rd_en      = 1'b1;
                rd_addr    = idx_reg;
                state_next = S_OUT;
            end
            S_OUT: begin
                if (!m_valid_reg || m_ready) begin
                    out_load                       = 1'b1;
                    m_valid_next                   = 1'b1;
                    m_data_next.out_proc_id        = rd_data.proc_id;
                    m_data_next.out_owner_id       = rd_data.owner_id;
                    m_data_next.out_load_pct       = rd_data.load_pct;
                    m_data_next.out_resident_pages = rd_data.resident_pages;
                    m_data_next.out_thread_count   = rd_data.thread_count;
                    m_data_next.out_final          = out_last;
                    m_data_next.records_dropped    = overflow_reg;
                    if (out_last) begin
                        count_next    = '0;
                        overflow_next = 1'b0;
                        state_next    = S_LOAD;
                    end else begin
                        rd_en    = 1'b1;
                        rd_addr  = idx_reg + IDX_W'(1);
                        idx_next = idx_reg + IDX_W'(1);
                    end
                end
            end
            default: begin
                state_next = S_LOAD;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_LOAD;
            count_reg    <= '0;
            overflow_reg <= 1'b0;
            pass_reg     <= '0;
            idx_reg      <= '0;
            moved_reg    <= 1'b0;
            m_valid_reg  <= 1'b0;
            cfg_reg      <= '0;
        end else begin
            state_reg    <= state_next;
            count_reg    <= count_next;
            overflow_reg <= overflow_next;
            pass_reg     <= pass_next;
            idx_reg      <= idx_next;
            moved_reg    <= moved_next;
            m_valid_reg  <= m_valid_next;
            cfg_reg      <= cfg_next;
        end
        carry_reg  <= carry_next;
        m_data_reg <= m_data_next;
    end

    // A sort only ever starts with at least two records held.
    `PRS_ASSERT_SAME(a_sort_needs_two, state_reg == S_PASS_RD, count_reg >= CNT_W'(2))
    // The compare step never runs past the last pair of the set.
    `PRS_ASSERT_SAME(a_step_in_range, state_reg == S_STEP, (CNT_W'(idx_reg) + CNT_W'(2)) <= count_reg)
    // Handing over the last result empties the store and reopens the input.
    `PRS_ASSERT_NEXT(a_last_empties, out_load && out_last, (count_reg == '0) && s_ready && !overflow_reg)

endmodule
